// File: rtl/assert_macros.svh
// Assertion macros for the audio run frame encoder.
// No dependencies; taken in by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ARFE_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// condition must never be seen out of reset
`define ARFE_NEVER(lbl, clk_s, rst_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) else $error(msg);

`endif

// File: rtl/arfe_pkg.sv
// Shared types, codes and constants of the audio run frame encoder.
// No dependencies; used by every module of the block but arfe_ram.
package arfe_pkg;

    localparam int BLOCK_BYTES_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int SEQ_CNT_W       = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_FORMAT_VERSION   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_WORD        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPRESSION_CODE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ADAPTIVE_CODE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PLAIN_CODE       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_ATTRIBUTE   = 3'd6;

    localparam logic [1:0] CMD_HEADER    = 2'd0;
    localparam logic [1:0] CMD_SAMPLE    = 2'd1;
    localparam logic [1:0] CMD_MARK_TIME = 2'd2;

    localparam logic [7:0] MAGIC_0 = 8'h20;
    localparam logic [7:0] MAGIC_1 = 8'h4E;
    localparam logic [7:0] MAGIC_2 = 8'h41;
    localparam logic [7:0] MAGIC_3 = 8'h46;

    localparam logic [SEQ_CNT_W-1:0] HEADER_BYTES = 4'd10;
    localparam logic [SEQ_CNT_W-1:0] TIME_BYTES   = 4'd12;
    localparam logic [SEQ_CNT_W-1:0] PLAIN_BYTES  = 4'd4;
    localparam logic [SEQ_CNT_W-1:0] PLAIN_SKIP   = 4'd2;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_TIME,
        KIND_ADAPT,
        KIND_PLAIN
    } kind_t;

    typedef struct packed {
        kind_t        kind;
        logic [15:0]  sample;
        logic         first;
        logic         last;
        logic [15:0]  len;
        logic [63:0]  utime;
    } job_t;

    typedef struct packed {
        logic [15:0] format_version;
        logic [15:0] rate_word;
        logic [7:0]  channel_count;
        logic [7:0]  compression_code;
        logic [7:0]  adaptive_code;
        logic [7:0]  plain_code;
        logic [15:0] time_attribute;
    } cfg_regs_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic busy;
        logic fill_at_limit;
    } back_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEQ,
        S_DECIDE,
        S_APPEND,
        S_RUN_HIGH,
        S_RUN_FILL,
        S_RUN_ADDR,
        S_RUN_DATA
    } back_state_t;

endpackage

// File: rtl/arfe_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module arfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/arfe_queue.sv
// Short job queue between the front and the back of the encoder.
// Depends on arfe_pkg.
module arfe_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  arfe_pkg::job_t        push_data,
    input  logic                  pop,
    output arfe_pkg::job_t        pop_data,
    output arfe_pkg::queue_stat_t stat
);

    localparam int D  = arfe_pkg::QUEUE_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    arfe_pkg::job_t mem [D];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign stat.full  = (count_reg == CW'(D));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(D - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(D - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/arfe_front.sv
// Front end: configuration registers, input beat acceptance and classification.
// Depends on arfe_pkg; feeds arfe_queue.
module arfe_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [arfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [arfe_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [95:0]                       s_axis_tdata,
    input  logic                              s_axis_tlast,
    input  logic [2:0]                        s_axis_tuser,
    input  arfe_pkg::queue_stat_t             q_stat,
    output logic                              q_push,
    output arfe_pkg::job_t                    q_data,
    output arfe_pkg::cfg_regs_t               cfg
);

    arfe_pkg::cfg_regs_t cfg_reg, cfg_next;

    logic [1:0] cmd;
    logic       keep;

    assign cfg_ready     = 1'b1;
    assign cfg           = cfg_reg;
    assign s_axis_tready = !q_stat.full;
    assign cmd           = s_axis_tuser[1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                arfe_pkg::REG_FORMAT_VERSION:   cfg_next.format_version   = cfg_data;
                arfe_pkg::REG_RATE_WORD:        cfg_next.rate_word        = cfg_data;
                arfe_pkg::REG_CHANNEL_COUNT:    cfg_next.channel_count    = cfg_data[7:0];
                arfe_pkg::REG_COMPRESSION_CODE: cfg_next.compression_code = cfg_data[7:0];
                arfe_pkg::REG_ADAPTIVE_CODE:    cfg_next.adaptive_code    = cfg_data[7:0];
                arfe_pkg::REG_PLAIN_CODE:       cfg_next.plain_code       = cfg_data[7:0];
                arfe_pkg::REG_TIME_ATTRIBUTE:   cfg_next.time_attribute   = cfg_data;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.format_version   <= 16'd1;
            cfg_reg.rate_word        <= 16'd8000;
            cfg_reg.channel_count    <= 8'd1;
            cfg_reg.compression_code <= 8'd1;
            cfg_reg.adaptive_code    <= 8'd1;
            cfg_reg.plain_code       <= 8'd0;
            cfg_reg.time_attribute   <= 16'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // adaptive wins over plain when both codes match
    always_comb
    begin
        keep          = 1'b0;
        q_data.kind   = arfe_pkg::KIND_HEADER;
        q_data.sample = s_axis_tdata[15:0];
        q_data.len    = s_axis_tdata[31:16];
        q_data.utime  = s_axis_tdata[95:32];
        q_data.first  = s_axis_tuser[2];
        q_data.last   = s_axis_tlast;
        case (cmd)
            arfe_pkg::CMD_HEADER:
            begin
                keep        = 1'b1;
                q_data.kind = arfe_pkg::KIND_HEADER;
            end
            arfe_pkg::CMD_MARK_TIME:
            begin
                keep        = 1'b1;
                q_data.kind = arfe_pkg::KIND_TIME;
            end
            arfe_pkg::CMD_SAMPLE:
            begin
                if (cfg_reg.compression_code == cfg_reg.adaptive_code)
                begin
                    keep        = 1'b1;
                    q_data.kind = arfe_pkg::KIND_ADAPT;
                end
                else if (cfg_reg.compression_code == cfg_reg.plain_code)
                begin
                    keep        = 1'b1;
                    q_data.kind = arfe_pkg::KIND_PLAIN;
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = s_axis_tvalid && s_axis_tready && keep;

endmodule

// File: rtl/arfe_back.sv
// Back end: byte sequencer for header, time, plain and run output, with run store.
// Depends on arfe_pkg and arfe_ram; drains arfe_queue.
module arfe_back #(
    parameter int BLOCK_BYTES = arfe_pkg::BLOCK_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  arfe_pkg::cfg_regs_t   cfg,
    input  arfe_pkg::queue_stat_t q_stat,
    input  arfe_pkg::job_t        q_data,
    output logic                  q_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,
    output logic                  m_axis_tlast,
    output arfe_pkg::back_stat_t  stat
);

    localparam int FW = $clog2(BLOCK_BYTES + 1);
    localparam int AW = $clog2(BLOCK_BYTES);
    localparam int CW = arfe_pkg::SEQ_CNT_W;

    function automatic logic [7:0] seq_byte(arfe_pkg::job_t j, arfe_pkg::cfg_regs_t c,
                                            logic [CW-1:0] n);
        logic [7:0] b;
        b = 8'h00;
        case (j.kind)
            arfe_pkg::KIND_HEADER:
            begin
                case (n)
                    4'd0:    b = arfe_pkg::MAGIC_0;
                    4'd1:    b = arfe_pkg::MAGIC_1;
                    4'd2:    b = arfe_pkg::MAGIC_2;
                    4'd3:    b = arfe_pkg::MAGIC_3;
                    4'd4:    b = c.format_version[15:8];
                    4'd5:    b = c.format_version[7:0];
                    4'd6:    b = c.rate_word[15:8];
                    4'd7:    b = c.rate_word[7:0];
                    4'd8:    b = c.channel_count;
                    4'd9:    b = c.compression_code;
                    default: b = 8'h00;
                endcase
            end
            arfe_pkg::KIND_TIME:
            begin
                case (n)
                    4'd2:    b = c.time_attribute[15:8];
                    4'd3:    b = c.time_attribute[7:0];
                    4'd4:    b = j.utime[63:56];
                    4'd5:    b = j.utime[55:48];
                    4'd6:    b = j.utime[47:40];
                    4'd7:    b = j.utime[39:32];
                    4'd8:    b = j.utime[31:24];
                    4'd9:    b = j.utime[23:16];
                    4'd10:   b = j.utime[15:8];
                    4'd11:   b = j.utime[7:0];
                    default: b = 8'h00;
                endcase
            end
            default:
            begin
                case (n)
                    4'd0:    b = j.len[15:8];
                    4'd1:    b = j.len[7:0];
                    4'd2:    b = j.sample[15:8];
                    4'd3:    b = j.sample[7:0];
                    default: b = 8'h00;
                endcase
            end
        endcase
        return b;
    endfunction

    arfe_pkg::back_state_t state_reg, state_next;
    arfe_pkg::job_t        work_reg;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    high_reg, high_next;
    logic          then_append_reg, then_append_next;
    logic          final_run_reg, final_run_next;
    logic          tail_reg, tail_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_last_reg, out_last_next;

    logic          out_free;
    logic [7:0]    w_hi;
    logic [7:0]    w_lo;
    logic [FW-1:0] eff_fill;
    logic [7:0]    eff_high;
    logic          flush;
    logic [FW-1:0] new_fill;
    logic          tail;
    logic [CW-1:0] seq_end;
    logic          seq_last;
    logic          run_end;

    logic          ram_we;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign w_hi     = work_reg.sample[15:8];
    assign w_lo     = work_reg.sample[7:0];
    assign eff_fill = work_reg.first ? '0 : fill_reg;
    assign eff_high = work_reg.first ? w_hi : high_reg;
    assign flush    = (w_hi != eff_high) && (eff_fill != '0);
    assign new_fill = flush ? FW'(1) : eff_fill + FW'(1);
    assign tail     = work_reg.last || (new_fill == FW'(BLOCK_BYTES));
    assign run_end  = (FW'(idx_reg) == fill_reg - FW'(1));
    assign seq_last = (cnt_reg == seq_end - CW'(1));

    always_comb
    begin
        case (work_reg.kind)
            arfe_pkg::KIND_HEADER: seq_end = arfe_pkg::HEADER_BYTES;
            arfe_pkg::KIND_TIME:   seq_end = arfe_pkg::TIME_BYTES;
            default:               seq_end = arfe_pkg::PLAIN_BYTES;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            arfe_pkg::S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = (q_data.kind == arfe_pkg::KIND_ADAPT) ?
                                 arfe_pkg::S_DECIDE : arfe_pkg::S_SEQ;
                end
            end
            arfe_pkg::S_SEQ:
            begin
                if (out_free && seq_last)
                begin
                    state_next = arfe_pkg::S_IDLE;
                end
            end
            arfe_pkg::S_DECIDE:
            begin
                state_next = flush ? arfe_pkg::S_RUN_HIGH : arfe_pkg::S_APPEND;
            end
            arfe_pkg::S_APPEND:
            begin
                state_next = tail_reg ? arfe_pkg::S_RUN_HIGH : arfe_pkg::S_IDLE;
            end
            arfe_pkg::S_RUN_HIGH:
            begin
                if (out_free)
                begin
                    state_next = arfe_pkg::S_RUN_FILL;
                end
            end
            arfe_pkg::S_RUN_FILL:
            begin
                if (out_free)
                begin
                    state_next = arfe_pkg::S_RUN_ADDR;
                end
            end
            arfe_pkg::S_RUN_ADDR:
            begin
                state_next = arfe_pkg::S_RUN_DATA;
            end
            arfe_pkg::S_RUN_DATA:
            begin
                if (out_free)
                begin
                    if (run_end)
                    begin
                        state_next = then_append_reg ? arfe_pkg::S_APPEND : arfe_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = arfe_pkg::S_RUN_ADDR;
                    end
                end
            end
            default:
            begin
                state_next = arfe_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop            = 1'b0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        fill_next        = fill_reg;
        high_next        = high_reg;
        then_append_next = then_append_reg;
        final_run_next   = final_run_reg;
        tail_next        = tail_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        case (state_reg)
            arfe_pkg::S_IDLE:
            begin
                q_pop    = !q_stat.empty;
                cnt_next = (q_data.kind == arfe_pkg::KIND_PLAIN && !q_data.first) ?
                           arfe_pkg::PLAIN_SKIP : '0;
            end
            arfe_pkg::S_SEQ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = seq_byte(work_reg, cfg, cnt_reg);
                    out_last_next  = seq_last;
                    cnt_next       = cnt_reg + CW'(1);
                end
            end
            arfe_pkg::S_DECIDE:
            begin
                tail_next = tail;
                if (flush)
                begin
                    then_append_next = 1'b1;
                    final_run_next   = !tail;
                end
                else
                begin
                    then_append_next = 1'b0;
                    fill_next        = eff_fill;
                    high_next        = w_hi;
                end
            end
            arfe_pkg::S_APPEND:
            begin
                ram_we    = 1'b1;
                fill_next = fill_reg + FW'(1);
                if (tail_reg)
                begin
                    final_run_next   = 1'b1;
                    then_append_next = 1'b0;
                end
            end
            arfe_pkg::S_RUN_HIGH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = high_reg;
                    out_last_next  = 1'b0;
                end
            end
            arfe_pkg::S_RUN_FILL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'(fill_reg);
                    out_last_next  = 1'b0;
                    idx_next       = '0;
                end
            end
            arfe_pkg::S_RUN_ADDR:
            begin
                ram_re = 1'b1;
            end
            arfe_pkg::S_RUN_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    out_last_next  = final_run_reg && run_end;
                    if (run_end)
                    begin
                        fill_next = '0;
                        if (then_append_reg)
                        begin
                            high_next = w_hi;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= arfe_pkg::S_IDLE;
            cnt_reg         <= '0;
            idx_reg         <= '0;
            fill_reg        <= '0;
            high_reg        <= '0;
            then_append_reg <= 1'b0;
            final_run_reg   <= 1'b0;
            tail_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            idx_reg         <= idx_next;
            fill_reg        <= fill_next;
            high_reg        <= high_next;
            then_append_reg <= then_append_next;
            final_run_reg   <= final_run_next;
            tail_reg        <= tail_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        if (q_pop)
        begin
            work_reg <= q_data;
        end
    end

    arfe_ram #(
        .WIDTH (8),
        .DEPTH (BLOCK_BYTES)
    ) u_run_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (w_lo),
        .rd_en   (ram_re),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    assign m_axis_tvalid      = out_valid_reg;
    assign m_axis_tdata       = out_byte_reg;
    assign m_axis_tlast       = out_last_reg;
    assign stat.busy          = (state_reg != arfe_pkg::S_IDLE);
    assign stat.fill_at_limit = (fill_reg == FW'(BLOCK_BYTES));

endmodule

// File: rtl/audio_run_frame_encoder.sv
// Top level of the audio run frame encoder: front, job queue and back end.
// Depends on arfe_pkg, arfe_front, arfe_queue, arfe_back and assert_macros.svh.
//
// channel   dir  beat contents
// cfg       in   cfg_index (register), cfg_data (value), always ready
// s_axis    in   one command or sample; tlast = last of call, tuser = cmd, first
// m_axis    out  one byte of the encoded stream; tlast = final byte of the item
//
// Back end fetches a queued job in its idle state, then gives one byte a cycle for header,
// time and plain output while m_axis is ready; each run byte from the store passes an
// address and a data state (registered read). An adaptive sample that emits nothing
// passes idle, decide and append. Reset clears the run state; the run store needs no clearing pass.
// A stalled m_axis holds the sequencer while the two-entry queue keeps taking beats until full.
`include "assert_macros.svh"

module audio_run_frame_encoder #(
    parameter int BLOCK_BYTES = arfe_pkg::BLOCK_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [arfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [arfe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [95:0]                      s_axis_tdata,  // sample, call_length, time_value
    input  logic                             s_axis_tlast,
    input  logic [2:0]                       s_axis_tuser,  // cmd, first_of_call
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // out_byte
    output logic                             m_axis_tlast
);

    arfe_pkg::cfg_regs_t   cfg;
    arfe_pkg::queue_stat_t q_stat;
    arfe_pkg::job_t        push_data;
    arfe_pkg::job_t        pop_data;
    arfe_pkg::back_stat_t  b_stat;
    logic                  q_push;
    logic                  q_pop;

    arfe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_data        (push_data),
        .cfg           (cfg)
    );

    arfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    arfe_back #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_stat        (q_stat),
        .q_data        (pop_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .stat          (b_stat)
    );

    `ARFE_NEVER(a_queue_state, clk, rst_n, q_stat.full && q_stat.empty, "queue full and empty")
    `ARFE_ASSERT(a_pop_when_idle, clk, rst_n, q_pop |-> !b_stat.busy, "job popped while busy")
    `ARFE_ASSERT(a_block_flushed, clk, rst_n, !b_stat.busy |-> !b_stat.fill_at_limit, "full run left")

endmodule
